@@ src/hrsl_pkg.sv @@
`timescale 1ns / 1ps

package hrsl_pkg;

    // score format and table shape
    localparam int SCORE_FRAC_BITS = 8;
    localparam int NUM_SPEEDS      = 4;
    localparam int ROW_COUNT       = 10;
    localparam int SCORE_W         = 16;
    localparam int ROW_W           = SCORE_W * NUM_SPEEDS;
    localparam int ROW_AW          = $clog2(ROW_COUNT);
    localparam int SCORE_ONE       = 1 << SCORE_FRAC_BITS;
    localparam int SCORE_MAX       = 32767;
    localparam int SCORE_MIN       = -32768;

    typedef logic signed [SCORE_W-1:0] t_score;
    typedef t_score [NUM_SPEEDS-1:0]   t_row;
    typedef logic [1:0]                t_speed;
    typedef logic [ROW_AW-1:0]         t_row_idx;

    typedef enum logic [2:0] {
        RISK_UNKNOWN  = 3'd0,
        RISK_CRITICAL = 3'd1,
        RISK_ELEVATED = 3'd2,
        RISK_WATCH    = 3'd3,
        RISK_STABLE   = 3'd4
    } t_risk;

    typedef enum logic [2:0] {
        CFG_EXPLORE_THRESHOLD = 3'd0,
        CFG_LEARN_RATE        = 3'd1,
        CFG_CRITICAL_HIGH     = 3'd2,
        CFG_CRITICAL_LOW      = 3'd3,
        CFG_ELEVATED_HIGH     = 3'd4,
        CFG_ELEVATED_LOW      = 3'd5,
        CFG_WATCH_HIGH        = 3'd6,
        CFG_CHANGE_LIMIT      = 3'd7
    } t_cfg_idx;

    localparam t_speed SPEED_SLOW   = 2'd0;
    localparam t_speed SPEED_MEDIUM = 2'd1;
    localparam t_speed SPEED_FAST   = 2'd2;
    localparam t_speed SPEED_URGENT = 2'd3;

    // last reported speed before any item went out
    localparam logic [2:0] LAST_SPEED_NONE = 3'd4;

    // rewards, saturated to the score range
    localparam int     REWARD_MISS_RAW = -10 * SCORE_ONE;
    localparam int     REWARD_HIT_RAW  = 2 * SCORE_ONE;
    localparam t_score REWARD_MISS     = (REWARD_MISS_RAW < SCORE_MIN) ?
                                         t_score'(SCORE_MIN) : t_score'(REWARD_MISS_RAW);
    localparam t_score REWARD_HIT      = (REWARD_HIT_RAW > SCORE_MAX) ?
                                         t_score'(SCORE_MAX) : t_score'(REWARD_HIT_RAW);
    // 0.3 per speed step below urgent, rounded half up
    localparam t_score REWARD_IDLE_SLOW   = t_score'((9 * SCORE_ONE + 5) / 10);
    localparam t_score REWARD_IDLE_MEDIUM = t_score'((6 * SCORE_ONE + 5) / 10);
    localparam t_score REWARD_IDLE_FAST   = t_score'((3 * SCORE_ONE + 5) / 10);
    localparam t_score REWARD_IDLE_URGENT = t_score'(5 / 10);

    function automatic t_score reward_for(input t_speed spd, input logic event_seen);
        t_score r;
        r = REWARD_IDLE_URGENT;
        if (event_seen && spd < SPEED_FAST) begin
            r = REWARD_MISS;
        end else if (event_seen) begin
            r = REWARD_HIT;
        end else begin
            unique case (spd)
                SPEED_SLOW:   r = REWARD_IDLE_SLOW;
                SPEED_MEDIUM: r = REWARD_IDLE_MEDIUM;
                SPEED_FAST:   r = REWARD_IDLE_FAST;
                SPEED_URGENT: r = REWARD_IDLE_URGENT;
                default:      r = REWARD_IDLE_URGENT;
            endcase
        end
        return r;
    endfunction

    // speed guessed for a risk class before any learning
    function automatic t_speed guess_speed(input t_risk risk);
        t_speed s;
        unique case (risk)
            RISK_CRITICAL: s = SPEED_URGENT;
            RISK_ELEVATED: s = SPEED_FAST;
            RISK_UNKNOWN:  s = SPEED_FAST;
            RISK_WATCH:    s = SPEED_MEDIUM;
            default:       s = SPEED_SLOW;
        endcase
        return s;
    endfunction

    // one-hot row held by a situation after reset
    function automatic t_row reset_row(input t_risk risk);
        t_row r;
        r = '0;
        r[guess_speed(risk)] = t_score'(SCORE_ONE);
        return r;
    endfunction

    // situation row: risk class times two plus trend
    function automatic t_row_idx situation(input t_risk risk, input logic trend);
        return t_row_idx'({risk, trend});
    endfunction

endpackage

@@ src/hrsl_ram.sv @@
`timescale 1ns / 1ps

module hrsl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/heart_rate_speed_learning_policy.sv @@
`timescale 1ns / 1ps

// Heart-rate speed policy with a learned score table. Each input item is one
// heart-rate sample; each yields exactly one result item, which passes through
// the stage 1, stage 2 and output registers after it is accepted. One item is
// taken per cycle when the output is not stalled, except that an item whose
// situation (risk class and trend) matches the item still in stage 1 is held
// until that item moves on: the ten score rows live in a single-port-read RAM
// with a registered read, and the row is read, updated and written back. The
// score table needs no clearing pass after reset; a row not yet written reads
// as its one-hot reset value. Configuration registers may be written only
// while no item is in flight.
module heart_rate_speed_learning_policy (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_heart_rate,
    input  logic [15:0] i_explore_draw,
    input  logic [1:0]  i_explore_speed,
    input  logic        i_lead_off,
    input  logic        i_learn_enable,
    input  logic        i_event_happened,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_speed,
    output logic [2:0]  o_risk_class,
    output logic        o_trend_changing,
    output logic        o_explored,
    output logic        o_speed_changed
);

    import hrsl_pkg::*;

    // configuration registers
    logic [15:0] r_explore_threshold;
    logic [7:0]  r_learn_rate;
    logic [7:0]  r_critical_high;
    logic [7:0]  r_critical_low;
    logic [7:0]  r_elevated_high;
    logic [7:0]  r_elevated_low;
    logic [7:0]  r_watch_high;
    logic [7:0]  r_change_limit;

    // running state
    logic [7:0]  r_prev_rate;
    logic [2:0]  r_last_speed;
    logic [ROW_COUNT-1:0] r_row_valid;

    // last row written, forwarded to a read issued at the same edge
    logic        r_fwd_valid;
    t_row_idx    r_fwd_row;
    t_row        r_fwd_data;

    // stage 0 classification
    t_risk       s0_risk;
    logic [7:0]  s0_diff;
    logic        s0_trend;
    t_row_idx    s0_row;
    logic        advance;
    logic        in_accept;

    // stage 1
    logic        r_s1_valid;
    t_row_idx    r_s1_row;
    t_risk       r_s1_risk;
    logic        r_s1_trend;
    logic        r_s1_explored;
    t_speed      r_s1_xspd;
    logic        r_s1_lead_off;
    logic        r_s1_learn;
    logic        r_s1_event;
    logic        r_s1_row_valid;
    logic [ROW_W-1:0] mem_rdata;
    t_row        s1_row_data;
    t_speed      s1_best;
    t_score      s1_best_score;
    t_speed      s1_pick;
    t_speed      s1_speed;
    t_score      s1_cur;
    t_score      s1_reward;
    logic signed [SCORE_W:0] s1_diff;

    // stage 2
    logic        r_s2_valid;
    t_row_idx    r_s2_row;
    t_row        r_s2_row_data;
    t_risk       r_s2_risk;
    logic        r_s2_trend;
    logic        r_s2_explored;
    t_speed      r_s2_speed;
    logic        r_s2_lead_off;
    logic        r_s2_learn;
    t_score      r_s2_cur;
    logic signed [SCORE_W:0] r_s2_diff;
    logic signed [SCORE_W+9:0] s2_prod;
    logic signed [SCORE_W+1:0] s2_step;
    logic signed [SCORE_W+1:0] s2_sum;
    t_score      s2_new_score;
    t_row        s2_new_row;
    t_speed      s2_out_speed;
    logic        mem_we;

    // output register
    logic        r_out_valid;
    t_speed      r_out_speed;
    t_risk       r_out_risk;
    logic        r_out_trend;
    logic        r_out_explored;
    logic        r_out_changed;

    localparam logic signed [SCORE_W+1:0] SUM_MAX = (SCORE_W + 2)'(SCORE_MAX);
    localparam logic signed [SCORE_W+1:0] SUM_MIN = (SCORE_W + 2)'(SCORE_MIN);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_explore_threshold <= 16'd13107;
            r_learn_rate        <= 8'd51;
            r_critical_high     <= 8'd140;
            r_critical_low      <= 8'd40;
            r_elevated_high     <= 8'd110;
            r_elevated_low      <= 8'd55;
            r_watch_high        <= 8'd95;
            r_change_limit      <= 8'd3;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_EXPLORE_THRESHOLD: r_explore_threshold <= i_cfg_data;
                CFG_LEARN_RATE:        r_learn_rate        <= i_cfg_data[7:0];
                CFG_CRITICAL_HIGH:     r_critical_high     <= i_cfg_data[7:0];
                CFG_CRITICAL_LOW:      r_critical_low      <= i_cfg_data[7:0];
                CFG_ELEVATED_HIGH:     r_elevated_high     <= i_cfg_data[7:0];
                CFG_ELEVATED_LOW:      r_elevated_low      <= i_cfg_data[7:0];
                CFG_WATCH_HIGH:        r_watch_high        <= i_cfg_data[7:0];
                CFG_CHANGE_LIMIT:      r_change_limit      <= i_cfg_data[7:0];
                default:               r_change_limit      <= r_change_limit;
            endcase
        end
    end

    // risk class of the incoming sample
    always_comb begin
        priority if (i_heart_rate == 8'd0) begin
            s0_risk = RISK_UNKNOWN;
        end else if (i_heart_rate > r_critical_high || i_heart_rate < r_critical_low) begin
            s0_risk = RISK_CRITICAL;
        end else if (i_heart_rate > r_elevated_high || i_heart_rate < r_elevated_low) begin
            s0_risk = RISK_ELEVATED;
        end else if (i_heart_rate > r_watch_high) begin
            s0_risk = RISK_WATCH;
        end else begin
            s0_risk = RISK_STABLE;
        end
    end

    // trend and situation row
    assign s0_diff  = (i_heart_rate > r_prev_rate) ? (i_heart_rate - r_prev_rate)
                                                   : (r_prev_rate - i_heart_rate);
    assign s0_trend = s0_diff > r_change_limit;
    assign s0_row   = situation(s0_risk, s0_trend);

    // pipeline moves when the output register is free or being taken;
    // hold an item whose row is still being updated one stage ahead
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = !advance || (r_s1_valid && r_s1_row == s0_row);
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_rate <= '0;
        end else if (in_accept) begin
            r_prev_rate <= i_heart_rate;
        end
    end

    // score table
    hrsl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROW_COUNT)
    ) u_score_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_s2_row),
        .i_wdata (s2_new_row),
        .i_re    (in_accept),
        .i_raddr (s0_row),
        .o_rdata (mem_rdata)
    );

    // stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_row       <= s0_row;
            r_s1_risk      <= s0_risk;
            r_s1_trend     <= s0_trend;
            r_s1_explored  <= i_explore_draw < r_explore_threshold;
            r_s1_xspd      <= i_explore_speed;
            r_s1_lead_off  <= i_lead_off;
            r_s1_learn     <= i_learn_enable;
            r_s1_event     <= i_event_happened;
            r_s1_row_valid <= r_row_valid[s0_row];
        end
    end

    // current row: forwarded write, stored row, or reset value
    always_comb begin
        priority if (r_fwd_valid && r_fwd_row == r_s1_row) begin
            s1_row_data = r_fwd_data;
        end else if (r_s1_row_valid) begin
            s1_row_data = t_row'(mem_rdata);
        end else begin
            s1_row_data = reset_row(r_s1_risk);
        end
    end

    // best score, lowest index wins ties
    always_comb begin
        s1_best       = SPEED_SLOW;
        s1_best_score = s1_row_data[0];
        for (int i = 1; i < NUM_SPEEDS; i++) begin
            if (s1_row_data[i] > s1_best_score) begin
                s1_best       = t_speed'(i);
                s1_best_score = s1_row_data[i];
            end
        end
    end

    // explore choice and safety floors
    assign s1_pick = r_s1_explored ? r_s1_xspd : s1_best;

    always_comb begin
        priority if (r_s1_risk == RISK_CRITICAL) begin
            s1_speed = SPEED_URGENT;
        end else if ((r_s1_risk == RISK_ELEVATED || r_s1_risk == RISK_UNKNOWN)
                     && s1_pick < SPEED_FAST) begin
            s1_speed = SPEED_FAST;
        end else begin
            s1_speed = s1_pick;
        end
    end

    // error between reward and the chosen score
    assign s1_cur    = s1_row_data[s1_speed];
    assign s1_reward = reward_for(s1_speed, r_s1_event);
    assign s1_diff   = (SCORE_W + 1)'(s1_reward) - (SCORE_W + 1)'(s1_cur);

    // stage 2 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (advance) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_s2_row      <= r_s1_row;
            r_s2_row_data <= s1_row_data;
            r_s2_risk     <= r_s1_risk;
            r_s2_trend    <= r_s1_trend;
            r_s2_explored <= r_s1_explored;
            r_s2_speed    <= s1_speed;
            r_s2_lead_off <= r_s1_lead_off;
            r_s2_learn    <= r_s1_learn;
            r_s2_cur      <= s1_cur;
            r_s2_diff     <= s1_diff;
        end
    end

    // learning step: floor(rate * error / 256), saturated sum
    assign s2_prod = $signed({1'b0, r_learn_rate}) * r_s2_diff;
    assign s2_step = s2_prod[SCORE_W+9:8];
    assign s2_sum  = (SCORE_W + 2)'(r_s2_cur) + s2_step;

    always_comb begin
        priority if (s2_sum > SUM_MAX) begin
            s2_new_score = t_score'(SCORE_MAX);
        end else if (s2_sum < SUM_MIN) begin
            s2_new_score = t_score'(SCORE_MIN);
        end else begin
            s2_new_score = s2_sum[SCORE_W-1:0];
        end
    end

    always_comb begin
        s2_new_row             = r_s2_row_data;
        s2_new_row[r_s2_speed] = s2_new_score;
    end

    assign mem_we = advance && r_s2_valid && r_s2_learn;

    // row written flags and forwarding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_fwd_valid <= 1'b0;
        end else if (mem_we) begin
            r_row_valid[r_s2_row] <= 1'b1;
            r_fwd_valid           <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_fwd_row  <= r_s2_row;
            r_fwd_data <= s2_new_row;
        end
    end

    // lead-off raises a slow reported speed to medium
    assign s2_out_speed = (r_s2_lead_off && r_s2_speed == SPEED_SLOW) ? SPEED_MEDIUM
                                                                       : r_s2_speed;

    // output register and last reported speed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_last_speed <= LAST_SPEED_NONE;
        end else if (advance) begin
            r_out_valid <= r_s2_valid;
            if (r_s2_valid) begin
                r_last_speed <= {1'b0, s2_out_speed};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s2_valid) begin
            r_out_speed    <= s2_out_speed;
            r_out_risk     <= r_s2_risk;
            r_out_trend    <= r_s2_trend;
            r_out_explored <= r_s2_explored;
            r_out_changed  <= {1'b0, s2_out_speed} != r_last_speed;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_speed          = r_out_speed;
    assign o_risk_class     = r_out_risk;
    assign o_trend_changing = r_out_trend;
    assign o_explored       = r_out_explored;
    assign o_speed_changed  = r_out_changed;

    // forwarded row is always one that has been written
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_valid |-> r_row_valid[r_fwd_row])
        else $error("forwarded row not marked written");

    // a score write comes from an item that moves into the output register
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> o_out_valid)
        else $error("score written without a result item");

    // critical risk always reports urgent speed
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_risk_class == RISK_CRITICAL) |-> o_speed == SPEED_URGENT)
        else $error("critical item below urgent speed");

    // elevated or unknown risk reports at least fast speed
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_risk_class == RISK_ELEVATED || o_risk_class == RISK_UNKNOWN))
        |-> o_speed >= SPEED_FAST)
        else $error("safety floor missed");

endmodule
